### sv/assert_macros.svh
// Assertion macros shared by the fill core RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define BEF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked while out of reset
`define BEF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### sv/bef_pkg.sv
// Shared constants and types for the extent fill core.
// No dependencies.
package bef_pkg;

  // Item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Result kinds
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Configuration register map
  localparam int          CFG_IDX_W        = 2;
  localparam int          CFG_DATA_W       = 9;
  localparam logic [1:0]  CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0]  CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [7:0]  WHITE = 8'hFF;

  // Frame memory request from the fill sequencer
  typedef struct packed {
    logic rd;
    logic wr;
  } fill_ctl_t;

endpackage

### sv/bef_frame_ram.sv
// Single-port frame store with a registered read; read data holds during writes.
// Imports bef_pkg, though no item of it is used here.
module bef_frame_ram
  import bef_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_r;

  // One access per cycle: write or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bef_fill_seq.sv
// Fill sequencer: column pass then row pass over the frame store.
// Depends on bef_pkg and assert_macros.svh; drives the store port while running.
`include "assert_macros.svh"
module bef_fill_seq
  import bef_pkg::*;
#(
  parameter int AW = 16,
  parameter int WW = 9,
  parameter int HW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WW-1:0] width,
  input  logic [HW-1:0] height,
  input  logic [7:0]    rdata,
  output fill_ctl_t     ctl,
  output logic [AW-1:0] addr,
  output logic          done
);

  localparam int CNTW = (WW > HW) ? WW : HW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FILL, S_NEXT, S_DONE} state_t;
  typedef enum logic {PASS_COL, PASS_ROW} pass_t;

  state_t          state_r;
  pass_t           pass_r;
  logic [AW-1:0]   line_base_r;
  logic [CNTW-1:0] line_cnt_r;
  logic [CNTW-1:0] pos_cnt_r;
  logic [AW-1:0]   addr_r;
  logic            issue_done_r;
  logic            found_r;
  logic [AW-1:0]   top_r;
  logic [AW-1:0]   bot_r;
  // read return tracking
  logic            rv_r;
  logic [AW-1:0]   ra_r;
  logic            rl_r;

  logic [AW-1:0]   stride;
  logic [AW-1:0]   line_step;
  logic [CNTW-1:0] len_m1;
  logic [CNTW-1:0] lines_m1;
  logic            issue;
  logic            hit;
  logic            found_any;
  logic [AW-1:0]   top_sel;
  logic [AW-1:0]   bot_sel;

  // Pass geometry: columns walk by width, rows walk by one
  always_comb begin
    if (pass_r == PASS_ROW) begin
      stride    = AW'(1);
      line_step = AW'(width);
      len_m1    = CNTW'(width) - CNTW'(1);
      lines_m1  = CNTW'(height) - CNTW'(1);
    end else begin
      stride    = AW'(width);
      line_step = AW'(1);
      len_m1    = CNTW'(height) - CNTW'(1);
      lines_m1  = CNTW'(width) - CNTW'(1);
    end
  end

  // Extent tracking on returned read data
  always_comb begin
    issue     = (state_r == S_SCAN) && !issue_done_r;
    hit       = rv_r && (rdata == WHITE);
    found_any = found_r || hit;
    top_sel   = found_r ? top_r : ra_r;
    bot_sel   = hit ? ra_r : bot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pass_r       <= PASS_COL;
      issue_done_r <= 1'b0;
      found_r      <= 1'b0;
      rv_r         <= 1'b0;
      rl_r         <= 1'b0;
    end else begin
      rv_r <= issue;
      ra_r <= addr_r;
      rl_r <= issue && (pos_cnt_r == len_m1);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r      <= S_SCAN;
            pass_r       <= PASS_COL;
            line_base_r  <= '0;
            line_cnt_r   <= '0;
            pos_cnt_r    <= '0;
            addr_r       <= '0;
            issue_done_r <= 1'b0;
            found_r      <= 1'b0;
          end
        end
        S_SCAN: begin
          // issue side
          if (issue) begin
            if (pos_cnt_r == len_m1) begin
              issue_done_r <= 1'b1;
            end else begin
              pos_cnt_r <= pos_cnt_r + CNTW'(1);
              addr_r    <= addr_r + stride;
            end
          end
          // return side: the latest white pixel is the bottom so far
          if (hit) begin
            found_r <= 1'b1;
            top_r   <= top_sel;
            bot_r   <= ra_r;
          end
          if (rv_r && rl_r) begin
            addr_r  <= top_sel;
            state_r <= found_any ? S_FILL : S_NEXT;
          end
        end
        S_FILL: begin
          if (addr_r == bot_r) begin
            state_r <= S_NEXT;
          end else begin
            addr_r <= addr_r + stride;
          end
        end
        S_NEXT: begin
          pos_cnt_r    <= '0;
          issue_done_r <= 1'b0;
          found_r      <= 1'b0;
          if (line_cnt_r == lines_m1) begin
            if (pass_r == PASS_COL) begin
              pass_r      <= PASS_ROW;
              line_base_r <= '0;
              line_cnt_r  <= '0;
              addr_r      <= '0;
              state_r     <= S_SCAN;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            line_cnt_r  <= line_cnt_r + CNTW'(1);
            line_base_r <= line_base_r + line_step;
            addr_r      <= line_base_r + line_step;
            state_r     <= S_SCAN;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ctl.rd = issue;
  assign ctl.wr = (state_r == S_FILL);
  assign addr   = addr_r;
  assign done   = (state_r == S_DONE);

  // Read data only comes back while a scan is in progress
  `BEF_ASSERT_IMP(a_ret_in_scan, rv_r, state_r == S_SCAN)
  // A fill never starts without an extent found in the scan
  `BEF_ASSERT_NXT(a_fill_found, (state_r == S_SCAN) && rv_r && rl_r && !found_any,
                  state_r == S_NEXT)

endmodule

### sv/binary_extent_fill_core.sv
// Extent fill core: load, read back and fill a grey-level frame in one memory.
// Load: no result. Read: result strobe the cycle after accept; 1 item/cycle while not busy.
// Run: per line, scan reads, white writes from first to last white pixel found, a line step;
// over W columns then H rows, then done; busy holds through it, then one run result strobe.
// Synchronous active-low reset clears pointers, sets width/height to 256 (clamped);
// a settle register also holds busy high after reset and each config write. Results cannot stall.
`include "assert_macros.svh"
module binary_extent_fill_core
  import bef_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_pixel_in,
  // result channel
  output logic                  out_valid,
  output logic                  out_result_kind,
  output logic [7:0]            out_pixel_out,
  output logic                  out_frame_last,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [PW-1:0] total_r;
  logic          settle_r;
  logic          busy_r;
  logic [PW-1:0] load_ptr_r;
  logic [PW-1:0] read_ptr_r;
  logic          out_valid_r;
  logic          out_kind_r;
  logic          out_last_r;

  logic          accept;
  logic          cfg_wr;
  logic          load_wr;
  logic          read_rd;
  logic          run_go;
  logic [WW-1:0] width_clamp;
  logic [HW-1:0] height_clamp;
  logic [PW-1:0] read_ptr_inc;

  fill_ctl_t     seq_ctl;
  logic [AW-1:0] seq_addr;
  logic          seq_done;

  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Handshakes and item decode
  always_comb begin
    busy         = busy_r || settle_r;
    cfg_ready    = !busy_r;
    accept       = start && !busy;
    cfg_wr       = cfg_valid && cfg_ready;
    load_wr      = accept && (in_mode == MODE_LOAD) && (load_ptr_r < total_r);
    read_rd      = accept && (in_mode == MODE_READ) && (read_ptr_r < total_r);
    run_go       = accept && (in_mode == MODE_RUN);
    read_ptr_inc = read_ptr_r + PW'(1);
  end

  // Register value clamping: zero reads as one, overlarge as the maximum
  always_comb begin
    if (cfg_wdata == '0) begin
      width_clamp  = WW'(1);
      height_clamp = HW'(1);
    end else begin
      width_clamp  = (32'(cfg_wdata) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_wdata);
      height_clamp = (32'(cfg_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata);
    end
  end

  // Configuration and frame size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
      settle_r <= 1'b1;
    end else begin
      settle_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= width_clamp;
          CFG_FRAME_HEIGHT: height_r <= height_clamp;
          default: ;
        endcase
      end
    end
  end

  // Pixel count, registered from the size registers
  always_ff @(posedge clk) begin
    total_r <= PW'(width_r) * PW'(height_r);
  end

  // Pointers, busy and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      load_ptr_r  <= '0;
      read_ptr_r  <= '0;
      out_valid_r <= 1'b0;
      out_kind_r  <= KIND_RUN;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= read_rd || seq_done;
      if (load_wr) begin
        load_ptr_r <= load_ptr_r + PW'(1);
      end
      if (read_rd) begin
        read_ptr_r <= read_ptr_inc;
        out_kind_r <= KIND_PIXEL;
        out_last_r <= (read_ptr_inc == total_r);
      end
      if (run_go) begin
        busy_r     <= 1'b1;
        load_ptr_r <= '0;
        read_ptr_r <= '0;
      end
      if (seq_done) begin
        busy_r     <= 1'b0;
        out_kind_r <= KIND_RUN;
        out_last_r <= 1'b0;
      end
    end
  end

  // Store port: sequencer while running, else loads and reads
  always_comb begin
    if (busy_r) begin
      ram_en    = seq_ctl.rd || seq_ctl.wr;
      ram_we    = seq_ctl.wr;
      ram_addr  = seq_addr;
      ram_wdata = WHITE;
    end else begin
      ram_en    = load_wr || read_rd;
      ram_we    = load_wr;
      ram_addr  = load_wr ? AW'(load_ptr_r) : AW'(read_ptr_r);
      ram_wdata = in_pixel_in;
    end
  end

  bef_frame_ram #(
    .AW (AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bef_fill_seq #(
    .AW (AW),
    .WW (WW),
    .HW (HW)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (run_go),
    .width  (width_r),
    .height (height_r),
    .rdata  (ram_rdata),
    .ctl    (seq_ctl),
    .addr   (seq_addr),
    .done   (seq_done)
  );

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_pixel_out   = (out_kind_r == KIND_PIXEL) ? ram_rdata : 8'd0;
  assign out_frame_last  = out_last_r;

  // Sequencer touches the store only during a run
  `BEF_ASSERT_IMP(a_seq_owns_ram, seq_ctl.rd || seq_ctl.wr, busy_r)
  // End of a run gives exactly a run-kind result beat next cycle
  `BEF_ASSERT_NXT(a_run_result, seq_done, out_valid_r && (out_kind_r == KIND_RUN))
  // A pixel read is answered in the following cycle
  `BEF_ASSERT_NXT(a_read_result, read_rd, out_valid_r && (out_kind_r == KIND_PIXEL))

endmodule
